/* rtl/core/color_keyed_pixel_blitter_assert.svh */
// Assertion helpers used by the blitter RTL.
`ifndef COLOR_KEYED_PIXEL_BLITTER_ASSERT_SVH
`define COLOR_KEYED_PIXEL_BLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKPB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ckpb same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CKPB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ckpb next-cycle check failed");

`endif

/* rtl/core/ckpb_pkg.sv */
package ckpb_pkg;

	localparam int PIX_W  = 16;
	localparam int OFF_W  = 19;
	localparam int DX_W   = 11;
	localparam int SIZE_W = 12;
	localparam int ROW_W  = 11;
	localparam int POS_W  = 13;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 3;

	localparam logic [SIZE_W-1:0] MAX_SIZE = 12'd2048;

	typedef enum logic [IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_REGION_WIDTH  = 3'd2,
		REG_REGION_HEIGHT = 3'd3,
		REG_KEY_COLOR     = 3'd4,
		REG_KEY_ENABLE    = 3'd5,
		REG_SOURCE_FORMAT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DX_W-1:0]   dest_x;
		logic [DX_W-1:0]   dest_y;
		logic [SIZE_W-1:0] region_width;
		logic [SIZE_W-1:0] region_height;
		logic [PIX_W-1:0]  key_color;
		logic              key_enable;
		logic              source_format;
	} cfg_t;

	// Screen position of the current transaction, as produced by the region walker.
	typedef struct packed {
		logic             draw;
		logic [POS_W-1:0] sx;
		logic [POS_W-1:0] sy;
		logic             done;
	} pos_t;

	// 555 to 565: green g becomes 2g+1, zero stays zero.
	function automatic logic [PIX_W-1:0] to565(input logic [PIX_W-1:0] p);
		logic [4:0] r;
		logic [4:0] g;
		logic [4:0] b;
		logic [5:0] g6;
		r  = p[14:10];
		g  = p[9:5];
		b  = p[4:0];
		g6 = (g == 5'd0) ? 6'd0 : {g, 1'b1};
		return {r, g6, b};
	endfunction

endpackage

/* rtl/core/color_keyed_pixel_blitter.sv */
// Color-keyed pixel blitter.
// Source channel: src_valid / src_stall carry one 16-bit source_pixel per transaction.
// Result channel: res_valid / res_stall carry one framebuffer write request per source
// transaction: write_enable, pixel_offset (row * SCREEN_WIDTH + column), pixel_color and
// region_done, which marks the last transaction of the configured region.
// Configuration: cfg_write with cfg_index and cfg_data writes one register per cycle;
// a write to any of the seven registers restarts the region walk, an unused index is
// ignored. Write only while the pipeline is empty.
// Throughput: one transaction per cycle while res_stall is low. A source transaction
// accepted on the source port passes two register stages before it shows on the result
// port: the region walker feeds the input stage, then the offset multiply and key
// compare feed the result register.
// Reset: configuration returns to origin, 1x1 region, keying off, format 565; both
// pipeline stages empty; the walker restarts at the first pixel.
// Result stall: the result register holds, the input stage holds behind it, and
// src_stall rises only once the input stage is also full, so no transaction is lost.
module color_keyed_pixel_blitter #(
	parameter int SCREEN_WIDTH  = 800,
	parameter int SCREEN_HEIGHT = 600
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_write,
	input  logic [ckpb_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ckpb_pkg::CFG_W-1:0]    cfg_data,

	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic [ckpb_pkg::PIX_W-1:0]    source_pixel,

	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          write_enable,
	output logic [ckpb_pkg::OFF_W-1:0]    pixel_offset,
	output logic [ckpb_pkg::PIX_W-1:0]    pixel_color,
	output logic                          region_done
);

	localparam int SW_W   = $clog2(SCREEN_WIDTH + 1);
	localparam int PROD_W = (ckpb_pkg::POS_W + SW_W + 1 > ckpb_pkg::OFF_W)
	                        ? ckpb_pkg::POS_W + SW_W + 1 : ckpb_pkg::OFF_W;
	localparam logic [ckpb_pkg::POS_W-1:0] SW_LIM = ckpb_pkg::POS_W'(SCREEN_WIDTH);
	localparam logic [ckpb_pkg::POS_W-1:0] SH_LIM = ckpb_pkg::POS_W'(SCREEN_HEIGHT);
	localparam logic [PROD_W-1:0]          SW_MUL = PROD_W'(SCREEN_WIDTH);

	ckpb_pkg::cfg_t cfg_q;
	ckpb_pkg::pos_t pos;
	ckpb_pkg::pos_t pos_s1;

	logic                       valid_s1;
	logic                       fmt_s1;
	logic [ckpb_pkg::PIX_W-1:0] pix_s1;

	logic                       res_valid_q;
	logic                       write_enable_q;
	logic [ckpb_pkg::OFF_W-1:0] pixel_offset_q;
	logic [ckpb_pkg::PIX_W-1:0] pixel_color_q;
	logic                       region_done_q;

	logic                       adv_out;
	logic                       load_s1;
	logic                       accept;
	logic                       cfg_clear;

	logic [PROD_W-1:0]          off_full;
	logic [ckpb_pkg::PIX_W-1:0] color;
	logic                       on_screen;
	logic                       keyed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.region_width  <= ckpb_pkg::SIZE_W'(1);
			cfg_q.region_height <= ckpb_pkg::SIZE_W'(1);
			cfg_q.key_color     <= '0;
			cfg_q.key_enable    <= 1'b0;
			cfg_q.source_format <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				ckpb_pkg::REG_DEST_X: begin
					cfg_q.dest_x <= cfg_data[ckpb_pkg::DX_W-1:0];
				end
				ckpb_pkg::REG_DEST_Y: begin
					cfg_q.dest_y <= cfg_data[ckpb_pkg::DX_W-1:0];
				end
				ckpb_pkg::REG_REGION_WIDTH: begin
					cfg_q.region_width <= cfg_data[ckpb_pkg::SIZE_W-1:0];
				end
				ckpb_pkg::REG_REGION_HEIGHT: begin
					cfg_q.region_height <= cfg_data[ckpb_pkg::SIZE_W-1:0];
				end
				ckpb_pkg::REG_KEY_COLOR: begin
					cfg_q.key_color <= cfg_data;
				end
				ckpb_pkg::REG_KEY_ENABLE: begin
					cfg_q.key_enable <= cfg_data[0];
				end
				ckpb_pkg::REG_SOURCE_FORMAT: begin
					cfg_q.source_format <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Restart the walk only on a write that lands on a register.
	assign cfg_clear = cfg_write
		&& (cfg_index inside {[ckpb_pkg::REG_DEST_X:ckpb_pkg::REG_SOURCE_FORMAT]});

	// Handshake: each stage advances when the one after it can take its contents.
	assign adv_out   = !res_valid_q || !res_stall;
	assign load_s1   = !valid_s1 || adv_out;
	assign src_stall = !load_s1;
	assign accept    = src_valid && load_s1;

	ckpb_region_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.clear   (cfg_clear),
		.advance (accept),
		.pos     (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
			pix_s1 <= source_pixel;
			fmt_s1 <= cfg_q.source_format;
		end
	end

	always_comb begin
		off_full  = PROD_W'(pos_s1.sy) * SW_MUL + PROD_W'(pos_s1.sx);
		color     = fmt_s1 ? ckpb_pkg::to565(pix_s1) : pix_s1;
		on_screen = (pos_s1.sx < SW_LIM) && (pos_s1.sy < SH_LIM);
		keyed     = cfg_q.key_enable && (color == cfg_q.key_color);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_out) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			region_done_q <= pos_s1.done;
			if (pos_s1.draw) begin
				write_enable_q <= on_screen && !keyed;
				pixel_offset_q <= off_full[ckpb_pkg::OFF_W-1:0];
				pixel_color_q  <= color;
			end else begin
				// Drop padding pixels: no write, zero payload.
				write_enable_q <= 1'b0;
				pixel_offset_q <= '0;
				pixel_color_q  <= '0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign write_enable = write_enable_q;
	assign pixel_offset = pixel_offset_q;
	assign pixel_color  = pixel_color_q;
	assign region_done  = region_done_q;

`include "color_keyed_pixel_blitter_assert.svh"

	`CKPB_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, src_stall, valid_s1 && res_valid_q)
	`CKPB_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv_out,
		valid_s1 && $stable(pos_s1) && $stable(pix_s1))
	`CKPB_ASSERT_NEXT(a_drain_empties, clk, arst_n, res_valid_q && !res_stall && !valid_s1,
		!res_valid_q)

endmodule

/* rtl/core/ckpb_region_walk.sv */
module ckpb_region_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  ckpb_pkg::cfg_t   cfg,
	input  logic             clear,
	input  logic             advance,
	output ckpb_pkg::pos_t   pos
);

	logic [ckpb_pkg::SIZE_W-1:0] col_q;
	logic [ckpb_pkg::ROW_W-1:0]  row_q;

	logic [ckpb_pkg::SIZE_W-1:0] w;
	logic [ckpb_pkg::SIZE_W-1:0] h;
	logic [ckpb_pkg::SIZE_W-1:0] row_len;
	logic [ckpb_pkg::SIZE_W-1:0] col_eff;
	logic [ckpb_pkg::ROW_W-1:0]  row_eff;
	logic [ckpb_pkg::SIZE_W-1:0] row_from_top;
	logic [ckpb_pkg::POS_W-1:0]  col_inc;
	logic [ckpb_pkg::POS_W-1:0]  row_inc;
	logic                        last_col;
	logic                        last_row;

	always_comb begin
		// Zero acts as one, oversize saturates.
		if (cfg.region_width == '0) begin
			w = ckpb_pkg::SIZE_W'(1);
		end else if (cfg.region_width > ckpb_pkg::MAX_SIZE) begin
			w = ckpb_pkg::MAX_SIZE;
		end else begin
			w = cfg.region_width;
		end
		if (cfg.region_height == '0) begin
			h = ckpb_pkg::SIZE_W'(1);
		end else if (cfg.region_height > ckpb_pkg::MAX_SIZE) begin
			h = ckpb_pkg::MAX_SIZE;
		end else begin
			h = cfg.region_height;
		end

		// Bitmap rows pad to an even pixel count.
		row_len = (cfg.source_format && w[0]) ? w + ckpb_pkg::SIZE_W'(1) : w;

		col_eff = (col_q >= row_len) ? '0 : col_q;
		row_eff = ({1'b0, row_q} >= h) ? '0 : row_q;

		col_inc  = {1'b0, col_eff} + ckpb_pkg::POS_W'(1);
		row_inc  = {2'b00, row_eff} + ckpb_pkg::POS_W'(1);
		last_col = col_inc >= {1'b0, row_len};
		last_row = row_inc >= {1'b0, h};

		row_from_top = cfg.source_format ? (h - ckpb_pkg::SIZE_W'(1) - {1'b0, row_eff})
		                                 : {1'b0, row_eff};

		pos.draw = col_eff < w;
		pos.sx   = {2'b00, cfg.dest_x} + {1'b0, col_eff};
		pos.sy   = {2'b00, cfg.dest_y} + {1'b0, row_from_top};
		pos.done = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[ckpb_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[ckpb_pkg::SIZE_W-1:0];
			end
		end
	end

endmodule
